// ===== hdl/hstp_pkg.sv =====
// Package for the triangular-probe hash set: widths, codes and the
// command/status structs shared by controller, datapath and top level.
// No dependencies.
package hstp_pkg;

  // Table geometry: slot index width and the number of slots in the store
  localparam int ADDR_W      = 10;
  localparam int TABLE_DEPTH = 1 << ADDR_W;
  localparam int VAL_W       = 32;
  localparam int LOAD_W      = 10;
  localparam int LG_W        = 4;
  localparam int PROD_W      = 2 * ADDR_W + 1;

  // Size register bounds and reset value
  localparam logic [LG_W-1:0] LG_MIN   = LG_W'(4);
  localparam logic [LG_W-1:0] LG_MAX   = LG_W'(ADDR_W);
  localparam logic [LG_W-1:0] LG_RESET = LG_W'(4);

  // Request codes
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DIRECT = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_PRESENT  = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_OCCUPIED = 2'd3
  } stat_e;

  // Which kind of result the datapath should build
  typedef enum logic [2:0] {
    RES_DONE     = 3'd0,
    RES_PRESENT  = 3'd1,
    RES_FULL     = 3'd2,
    RES_OCCUPIED = 3'd3,
    RES_READ     = 3'd4,
    RES_CLEAR    = 3'd5
  } res_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SLOT,
    ST_RD,
    ST_EVAL,
    ST_CLEAR,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic calc_tri;
    logic set_slot;
    logic mem_rd;
    logic mem_wr;
    logic step;
    logic clr_wr;
    logic load_clr;
    logic out_load;
    res_e kind;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    req_e              req;
    logic              bad;
    logic              empty;
    logic              match;
    logic              probes_done;
    logic              clr_last;
    logic              out_busy;
    logic [LOAD_W-1:0] load;
  } dp_stat_t;

endpackage

// ===== hdl/hstp_if.sv =====
// Valid/ready channel interfaces for request and result items.
// Depends on hstp_pkg for the field widths.
interface hstp_in_if;
  import hstp_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [VAL_W-1:0]  value;
  logic [VAL_W-1:0]  hash;
  logic [ADDR_W-1:0] probe_index;

  modport source (output valid, req_type, value, hash, probe_index, input ready);
  modport sink   (input valid, req_type, value, hash, probe_index, output ready);
endinterface

interface hstp_out_if;
  import hstp_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] slot;
  logic              found;
  logic [VAL_W-1:0]  read_value;
  logic [LOAD_W-1:0] load_count;

  modport source (output valid, status, slot, found, read_value, load_count, input ready);
  modport sink   (input valid, status, slot, found, read_value, load_count, output ready);
endinterface

// ===== hdl/hash_set_triangular_probe_top.sv =====
// Top level of the triangular-probe hash set: joins controller and datapath
// to the request and result channels. Depends on hstp_pkg, hstp_if,
// hstp_ctrl and hstp_dp.
//
// Open-addressing set of 32-bit values held in a table of 1024 slots (one
// write port, one registered read port), probing slot (hash + i*(i+1)/2)
// mod 2^log2_table_size. One request is worked at a time and gives exactly
// one result item, held in an output register while the next request is
// taken. Probe read and direct insert read a single slot; an insert visits
// probe after probe, as each probe needs one registered read of the table
// memory and one compare. A refused write is answered without reading the
// table. Clear sweeps the whole table one slot a cycle. After reset the same
// clearing pass runs before the first request is accepted; configuration
// writes are taken throughout.
module hash_set_triangular_probe_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hstp_pkg::LG_W-1:0]   cfg_wdata_i,
  hstp_in_if.sink                     req_i,
  hstp_out_if.source                  rsp_o
);
  import hstp_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequencer
  hstp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table, probe arithmetic and result register
  hstp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_type_i    (req_i.req_type),
    .value_i       (req_i.value),
    .hash_i        (req_i.hash),
    .probe_index_i (req_i.probe_index),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .status_o      (rsp_o.status),
    .slot_o        (rsp_o.slot),
    .found_o       (rsp_o.found),
    .read_value_o  (rsp_o.read_value),
    .load_count_o  (rsp_o.load_count)
  );

  // Sweep writes and value stores never share the write port
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.clr_wr && cmd.mem_wr))
    else $error("clear sweep and value store collide");

  // Every stored value raises the load by one
  a_load_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mem_wr |=> stat.load == $past(stat.load) + LOAD_W'(1))
    else $error("load count not advanced after a store");

  // A refused write reports no slot
  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == STAT_FULL) |-> rsp_o.slot == '0)
    else $error("too-full result carries a slot");

  // No request is taken while the table is being swept
  a_no_accept_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !req_i.ready)
    else $error("request accepted during clearing sweep");

endmodule

// ===== hdl/hstp_ctrl.sv =====
// Controller state machine for the hash set: sequences decode, probing,
// clearing sweeps and result hand-off. Depends on hstp_pkg.
module hstp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hstp_pkg::dp_stat_t stat_i,
  output hstp_pkg::ctl_cmd_t cmd_o
);
  import hstp_pkg::*;

  state_e state_q, state_d;
  res_e   kind_q, kind_d;
  logic   is_write;

  assign is_write = (stat_i.req == REQ_INSERT) || (stat_i.req == REQ_DIRECT);

  // State and result kind registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      kind_q  <= RES_DONE;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    case (state_q)
      ST_INIT: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat_i.req == REQ_CLEAR) begin
          state_d = ST_CLEAR;
        end else if (is_write && stat_i.bad) begin
          kind_d  = RES_FULL;
          state_d = ST_DONE;
        end else begin
          state_d = ST_SLOT;
        end
      end
      ST_SLOT: state_d = ST_RD;
      ST_RD:   state_d = ST_EVAL;
      ST_EVAL: begin
        state_d = ST_DONE;
        case (stat_i.req)
          REQ_READ:   kind_d = RES_READ;
          REQ_DIRECT: kind_d = stat_i.empty ? RES_DONE : RES_OCCUPIED;
          REQ_INSERT: begin
            if (stat_i.empty) begin
              kind_d = RES_DONE;
            end else if (stat_i.match) begin
              kind_d = RES_PRESENT;
            end else if (stat_i.probes_done) begin
              kind_d = RES_FULL;
            end else begin
              state_d = ST_RD;
            end
          end
          default: kind_d = RES_CLEAR;
        endcase
      end
      ST_CLEAR: begin
        if (stat_i.clr_last) begin
          kind_d  = RES_CLEAR;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        if (stat_i.req == REQ_CLEAR) begin
          cmd_o.load_clr = 1'b1;
        end else if (!(is_write && stat_i.bad)) begin
          cmd_o.calc_tri = 1'b1;
        end
      end
      ST_SLOT: cmd_o.set_slot = 1'b1;
      ST_RD:   cmd_o.mem_rd = 1'b1;
      ST_EVAL: begin
        if (is_write && stat_i.empty) begin
          cmd_o.mem_wr = 1'b1;
        end else if (stat_i.req == REQ_INSERT && !stat_i.match && !stat_i.probes_done) begin
          cmd_o.step = 1'b1;
        end
      end
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_DONE:  cmd_o.out_load = !stat_i.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== hdl/hstp_dp.sv =====
// Datapath for the hash set: slot store memory, probe address arithmetic,
// load count, size register and result register. Depends on hstp_pkg.
module hstp_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [hstp_pkg::LG_W-1:0] cfg_wdata_i,
  input  logic [1:0]              req_type_i,
  input  logic [hstp_pkg::VAL_W-1:0] value_i,
  input  logic [hstp_pkg::VAL_W-1:0] hash_i,
  input  logic [hstp_pkg::ADDR_W-1:0] probe_index_i,
  input  hstp_pkg::ctl_cmd_t      cmd_i,
  output hstp_pkg::dp_stat_t      stat_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic [hstp_pkg::ADDR_W-1:0] slot_o,
  output logic                    found_o,
  output logic [hstp_pkg::VAL_W-1:0] read_value_o,
  output logic [hstp_pkg::LOAD_W-1:0] load_count_o
);
  import hstp_pkg::*;

  logic [VAL_W-1:0]  mem [TABLE_DEPTH];

  logic [LG_W-1:0]   lg_q;
  req_e              req_q;
  logic [VAL_W-1:0]  val_q;
  logic [ADDR_W-1:0] h_q;
  logic [ADDR_W-1:0] pn_q, pn_d;
  logic [ADDR_W-1:0] tri_q;
  logic [ADDR_W-1:0] cnt_q;
  logic [ADDR_W-1:0] slot_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic [LOAD_W-1:0] load_q;
  logic [VAL_W-1:0]  rdata_q;
  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [ADDR_W-1:0] oslot_q;
  logic              found_q;
  logic [VAL_W-1:0]  rval_q;
  logic [LOAD_W-1:0] oload_q;

  logic [LG_W-1:0]   lg_c;
  logic [ADDR_W:0]   size;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W:0]   pn_inc;
  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic [VAL_W-1:0]  stored;
  logic              hit;

  // Size register, clamped to the supported range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q <= LG_RESET;
    end else if (cfg_we_i) begin
      lg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    lg_c = lg_q;
    if (lg_q < LG_MIN) lg_c = LG_MIN;
    if (lg_q > LG_MAX) lg_c = LG_MAX;
  end

  assign size = (ADDR_W + 1)'(1) << lg_c;
  assign mask = ADDR_W'(size - (ADDR_W + 1)'(1));

  // Probe number for the request; direct insert uses one below the given index (zero for index zero)
  always_comb begin
    case (req_e'(req_type_i))
      REQ_DIRECT: pn_d = (probe_index_i != '0) ? probe_index_i - ADDR_W'(1) : '0;
      REQ_READ:   pn_d = probe_index_i;
      default:    pn_d = '0;
    endcase
  end

  // Triangular offset pn*(pn+1)/2, only its low bits matter
  assign pn_inc = {1'b0, pn_q} + (ADDR_W + 1)'(1);
  assign prod   = PROD_W'(pn_q) * PROD_W'(pn_inc);

  // Request capture and probe walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_e'(req_type_i);
      val_q <= value_i;
      h_q   <= hash_i[ADDR_W-1:0];
      pn_q  <= pn_d;
      cnt_q <= '0;
    end
    if (cmd_i.calc_tri) tri_q <= prod[ADDR_W:1];
    if (cmd_i.set_slot) begin
      slot_q <= (h_q + tri_q) & mask;
    end else if (cmd_i.step) begin
      slot_q <= (slot_q + cnt_q + ADDR_W'(1)) & mask;
      cnt_q  <= cnt_q + ADDR_W'(1);
    end
  end

  // Clearing sweep address; wraps back to zero at the end of each sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
    end
  end

  // Load count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
    end else if (cmd_i.load_clr) begin
      load_q <= '0;
    end else if (cmd_i.mem_wr) begin
      load_q <= load_q + LOAD_W'(1);
    end
  end

  // Slot store: one write port, one registered read port
  assign stored  = val_q + VAL_W'(1);
  assign wr_addr = cmd_i.clr_wr ? clr_addr_q : slot_q;
  assign wr_data = cmd_i.clr_wr ? '0 : stored;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr || cmd_i.mem_wr) mem[wr_addr] <= wr_data;
    if (cmd_i.mem_rd) rdata_q <= mem[slot_q];
  end

  // Status towards the controller
  assign hit = (rdata_q != '0);
  always_comb begin
    stat_o             = '0;
    stat_o.req         = req_q;
    stat_o.bad         = ({load_q, 1'b1} >= size) || (val_q == '1);
    stat_o.empty       = !hit;
    stat_o.match       = (rdata_q == stored);
    stat_o.probes_done = (cnt_q == mask);
    stat_o.clr_last    = (clr_addr_q == '1);
    stat_o.out_busy    = out_valid_q && !out_ready_i;
    stat_o.load        = load_q;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      oload_q <= load_q;
      oslot_q <= slot_q;
      found_q <= 1'b0;
      rval_q  <= '0;
      case (cmd_i.kind)
        RES_DONE:     status_q <= STAT_DONE;
        RES_PRESENT:  status_q <= STAT_PRESENT;
        RES_OCCUPIED: status_q <= STAT_OCCUPIED;
        RES_READ: begin
          status_q <= STAT_DONE;
          found_q  <= hit;
          rval_q   <= hit ? rdata_q - VAL_W'(1) : '0;
        end
        RES_CLEAR: begin
          status_q <= STAT_DONE;
          oslot_q  <= '0;
        end
        default: begin
          status_q <= STAT_FULL;
          oslot_q  <= '0;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign slot_o       = oslot_q;
  assign found_o      = found_q;
  assign read_value_o = rval_q;
  assign load_count_o = oload_q;

endmodule
